// ===== hdl/atp_pkg.sv =====
// Shared types, constants and the arctangent table for the tilt angle block.
package atp_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 7;
  localparam int STAGES_DEF  = 16;
  localparam int INT_FRAC    = 20;
  localparam int ATAN_LEN    = 24;
  localparam int PITCH_W     = FRAC_W + 8;
  localparam int ROLL_W      = FRAC_W + 9;
  localparam int ROOT_W      = SAMPLE_W + 8;
  localparam int RAD_W       = 2 * SAMPLE_W + 16;
  localparam int CORD_W      = SAMPLE_W + 20;
  localparam int ANG_W       = 30;

  typedef enum logic [1:0] {
    FORCE_NONE,
    FORCE_ZERO,
    FORCE_NEG180
  } force_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [ROLL_W-1:0]  roll_angle;
  } out_beat_t;

  typedef struct packed {
    logic [RAD_W-1:0]           rem;
    logic [ROOT_W-1:0]          root;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
  } sqrt_lane_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] xx;
    logic signed [CORD_W-1:0] yy;
    logic signed [ANG_W-1:0]  ang;
    force_e                   frc;
  } cordic_lane_t;

  // atan(2^-i) in degrees, 20 fraction bits, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0: v = ANG_W'(47185920);
      1: v = ANG_W'(27855475);
      2: v = ANG_W'(14718068);
      3: v = ANG_W'(7471121);
      4: v = ANG_W'(3750058);
      5: v = ANG_W'(1876857);
      6: v = ANG_W'(938658);
      7: v = ANG_W'(469357);
      8: v = ANG_W'(234682);
      9: v = ANG_W'(117342);
      10: v = ANG_W'(58671);
      11: v = ANG_W'(29335);
      12: v = ANG_W'(14668);
      13: v = ANG_W'(7334);
      14: v = ANG_W'(3667);
      15: v = ANG_W'(1833);
      16: v = ANG_W'(917);
      17: v = ANG_W'(458);
      18: v = ANG_W'(229);
      19: v = ANG_W'(115);
      20: v = ANG_W'(57);
      21: v = ANG_W'(29);
      22: v = ANG_W'(14);
      23: v = ANG_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/atp_sqrt_cell.sv =====
// One root bit of the pipelined integer square root.
module atp_sqrt_cell import atp_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic       clk_i,
  input  logic       en_i,
  input  sqrt_lane_t lane_i,
  output sqrt_lane_t lane_o
);

  sqrt_lane_t lane_d, lane_q;
  logic [RAD_W-1:0] trial;

  always_comb begin
    lane_d = lane_i;
    // (2*root + 2^bit) * 2^bit, root holds only bits above this one
    trial = (RAD_W'(lane_i.root) << (BIT + 1)) | (RAD_W'(1) << (2 * BIT));
    if (lane_i.rem >= trial) begin
      lane_d.rem  = lane_i.rem - trial;
      lane_d.root = lane_i.root | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== hdl/atp_cordic_cell.sv =====
// One CORDIC vectoring micro-rotation, registered.
module atp_cordic_cell import atp_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  cordic_lane_t lane_i,
  output cordic_lane_t lane_o
);

  cordic_lane_t lane_d, lane_q;
  logic signed [CORD_W-1:0] dx, dy;

  always_comb begin
    lane_d = lane_i;
    dx = lane_i.yy >>> STEP;
    dy = lane_i.xx >>> STEP;
    if (!lane_i.yy[CORD_W-1]) begin
      lane_d.xx  = lane_i.xx + dx;
      lane_d.yy  = lane_i.yy - dy;
      lane_d.ang = lane_i.ang + atan_deg(STEP);
    end else begin
      lane_d.xx  = lane_i.xx - dx;
      lane_d.yy  = lane_i.yy + dy;
      lane_d.ang = lane_i.ang - atan_deg(STEP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== hdl/accel_tilt_pitch_roll.sv =====
// Top level: accelerometer pitch and roll through a sqrt and two CORDIC cell chains.
// Takes one (x, y, z) sample per clock unless stalled, and returns pitch =
// atan2(y, sqrt(x^2+z^2)) and roll = atan2(-x, z) in degrees with 7 fraction bits,
// rounded to nearest, clamped to +/-90 and +/-180. One beat per cycle sustained
// while not stalled; the stages are square/sum, one sqrt cell per root bit,
// quadrant fold, one CORDIC cell per micro-rotation, and round/clamp.
// The whole pipeline freezes while a finished beat is held at the output
// and stall_i is high; stall_o follows that condition. atan2(0,0) gives 0,
// and roll of x=0, z<0 gives -180 degrees.
module accel_tilt_pitch_roll import atp_pkg::*; #(
  parameter int CORDIC_STAGES = STAGES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_beat_t  in_beat_i,
  output logic      stall_o,
  output logic      out_valid_o,
  output out_beat_t out_beat_o,
  input  logic      stall_i
);

  localparam int LAT = 2 + ROOT_W + 1 + CORDIC_STAGES + 1;
  localparam int SH  = INT_FRAC - FRAC_W;

  logic           adv;
  logic [LAT-1:0] valid_q;

  // pipeline advances unless a held beat is stalled
  assign adv     = !(valid_q[LAT-1] && stall_i);
  assign stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[LAT-2:0], in_valid_i};
    end
  end

  // stage A: squares
  logic signed [SAMPLE_W-1:0]   ax_q, ay_q, az_q;
  logic signed [2*SAMPLE_W-1:0] sqx_q, sqz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q  <= in_beat_i.accel_x;
      ay_q  <= in_beat_i.accel_y;
      az_q  <= in_beat_i.accel_z;
      sqx_q <= in_beat_i.accel_x * in_beat_i.accel_x;
      sqz_q <= in_beat_i.accel_z * in_beat_i.accel_z;
    end
  end

  // stage B: sum of squares, scaled by 2^16 for 8 root fraction bits
  sqrt_lane_t sq_lane [ROOT_W+1];
  sqrt_lane_t sb_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q.rem  <= {(2*SAMPLE_W)'($unsigned(sqx_q)) + (2*SAMPLE_W)'($unsigned(sqz_q)),
                    16'd0};
      sb_q.root <= '0;
      sb_q.x    <= ax_q;
      sb_q.y    <= ay_q;
      sb_q.z    <= az_q;
    end
  end

  assign sq_lane[0] = sb_q;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    atp_sqrt_cell #(.BIT(ROOT_W - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .lane_i (sq_lane[k]),
      .lane_o (sq_lane[k+1])
    );
  end

  // quadrant fold and special-case tagging
  sqrt_lane_t               sl;
  cordic_lane_t             pre_p_d, pre_r_d, pre_p_q, pre_r_q;
  logic signed [CORD_W-1:0] rx, ry;

  assign sl = sq_lane[ROOT_W];

  always_comb begin
    pre_p_d.xx  = CORD_W'($unsigned(sl.root)) <<< 8;
    pre_p_d.yy  = CORD_W'(sl.y) <<< 16;
    pre_p_d.ang = '0;
    pre_p_d.frc = (sl.y == '0 && sl.root == '0) ? FORCE_ZERO : FORCE_NONE;

    ry = -(CORD_W'(sl.x) <<< 16);
    rx = CORD_W'(sl.z) <<< 16;
    pre_r_d.frc = FORCE_NONE;
    if (sl.x == '0 && sl.z < 0) begin
      pre_r_d.frc = FORCE_NEG180;
    end else if (sl.x == '0 && sl.z == '0) begin
      pre_r_d.frc = FORCE_ZERO;
    end
    pre_r_d.xx  = rx;
    pre_r_d.yy  = ry;
    pre_r_d.ang = '0;
    if (rx < 0) begin
      if (ry >= 0) begin
        pre_r_d.xx  = ry;
        pre_r_d.yy  = -rx;
        pre_r_d.ang = ANG_W'(90) <<< INT_FRAC;
      end else begin
        pre_r_d.xx  = -ry;
        pre_r_d.yy  = rx;
        pre_r_d.ang = -(ANG_W'(90) <<< INT_FRAC);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pre_p_q <= pre_p_d;
      pre_r_q <= pre_r_d;
    end
  end

  // CORDIC cell chains, pitch and roll side by side
  cordic_lane_t p_lane [CORDIC_STAGES+1];
  cordic_lane_t r_lane [CORDIC_STAGES+1];

  assign p_lane[0] = pre_p_q;
  assign r_lane[0] = pre_r_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    atp_cordic_cell #(.STEP(i)) u_pitch (
      .clk_i  (clk_i),
      .en_i   (adv),
      .lane_i (p_lane[i]),
      .lane_o (p_lane[i+1])
    );
    atp_cordic_cell #(.STEP(i)) u_roll (
      .clk_i  (clk_i),
      .en_i   (adv),
      .lane_i (r_lane[i]),
      .lane_o (r_lane[i+1])
    );
  end

  // round to nearest (ties up) and clamp
  function automatic logic signed [ANG_W-1:0] finish(input cordic_lane_t l,
                                                     input int lim_deg);
    logic signed [ANG_W-1:0] a, r, lim;
    case (l.frc)
      FORCE_ZERO:   a = '0;
      FORCE_NEG180: a = -(ANG_W'(180) <<< INT_FRAC);
      default:      a = l.ang;
    endcase
    r   = (a + (ANG_W'(1) <<< (SH - 1))) >>> SH;
    lim = ANG_W'(lim_deg) <<< FRAC_W;
    if (r > lim) begin
      r = lim;
    end
    if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  logic signed [ANG_W-1:0] pitch_full, roll_full;
  out_beat_t               out_q;

  assign pitch_full = finish(p_lane[CORDIC_STAGES], 90);
  assign roll_full  = finish(r_lane[CORDIC_STAGES], 180);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.pitch_angle <= pitch_full[PITCH_W-1:0];
      out_q.roll_angle  <= roll_full[ROLL_W-1:0];
    end
  end

  assign out_beat_o  = out_q;
  assign out_valid_o = valid_q[LAT-1];

  // the pipeline only freezes behind a held, stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (out_valid_o && stall_i))
    else $error("stall_o without a stalled result");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.pitch_angle <= 11520 && out_beat_o.pitch_angle >= -11520))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.roll_angle <= 23040 && out_beat_o.roll_angle >= -23040))
    else $error("roll out of range");

endmodule
